// ===== sv/twat_pkg.sv =====
`default_nettype none
package twat_pkg;

    localparam int DEF_TICK_SLOTS = 32;
    localparam int SLOT_W = 8;
    localparam int BUF_W = 17;
    localparam logic [BUF_W-1:0] BUF_RESET = 17'd4096;
    localparam logic [BUF_W-1:0] BUF_MAX = 17'd65536;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_START   = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_ACK_REQ = 3'd3,
        CMD_ACK_RX  = 3'd4,
        CMD_SET_CUR = 3'd5,
        CMD_NEXT    = 3'd6,
        CMD_LENGTH  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_FULL       = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_NO_SPACE   = 3'd4,
        ST_TOO_SMALL  = 3'd5
    } status_t;

    typedef struct packed {
        logic [31:0] tick_time;
        logic [15:0] offset;
        logic [7:0]  acks;
        logic [15:0] messages;
    } rec_t;

    localparam rec_t REC_RESET = '{tick_time: 32'hFFFF_FFFF, offset: 16'd0,
                                   acks: 8'd0, messages: 16'd0};

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] tick_time;
        logic        time_given;
        logic [7:0]  ack_count;
        logic [15:0] byte_count;
    } in_t;

    typedef struct packed {
        status_t          status;
        logic [SLOT_W-1:0] slot_index;
        logic [31:0]      value;
        logic [BUF_W-1:0] free_bytes;
    } res_t;

    typedef struct packed {
        logic              clr;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        rec_t              wr_data;
    } mem_req_t;

endpackage
`default_nettype wire

// ===== sv/twat_mem.sv =====
`default_nettype none
module twat_mem #(
    parameter int TICK_SLOTS = twat_pkg::DEF_TICK_SLOTS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire twat_pkg::mem_req_t req,
    output twat_pkg::rec_t          rdata
);
    import twat_pkg::*;

    localparam int IW = $clog2(TICK_SLOTS);

    rec_t mem_array [TICK_SLOTS];
    logic [TICK_SLOTS-1:0] valid_reg;
    rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clr) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr[IW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_array[req.wr_addr[IW-1:0]] <= req.wr_data;
        end
    end

    // entries never written since clear read as the reset record
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rdata_reg <= valid_reg[req.rd_addr[IW-1:0]] ? mem_array[req.rd_addr[IW-1:0]]
                                                        : REC_RESET;
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/twat_seq.sv =====
`default_nettype none
module twat_seq #(
    parameter int TICK_SLOTS = twat_pkg::DEF_TICK_SLOTS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [16:0]        cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire twat_pkg::in_t      in_item,
    output logic                    res_valid,
    input  wire logic               res_take,
    output twat_pkg::res_t          res,
    output twat_pkg::mem_req_t      mreq,
    input  wire twat_pkg::rec_t     rdata
);
    import twat_pkg::*;

    localparam int IW = $clog2(TICK_SLOTS);
    localparam int LW = $clog2(TICK_SLOTS + 1);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_RUN  = 14'b00000000000010,
        S_SRD  = 14'b00000000000100,
        S_SCHK = 14'b00000000001000,
        S_DRD  = 14'b00000000010000,
        S_DWR  = 14'b00000000100000,
        S_RRD  = 14'b00000001000000,
        S_RCHK = 14'b00000010000000,
        S_FREE = 14'b00000100000000,
        S_NRD  = 14'b00001000000000,
        S_NCHK = 14'b00010000000000,
        S_MWR  = 14'b00100000000000,
        S_DONE = 14'b01000000000000,
        S_SPARE = 14'b10000000000000
    } state_t;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IW+1)'(TICK_SLOTS)) begin
            s = s - (IW+1)'(TICK_SLOTS);
        end
        return s[IW-1:0];
    endfunction

    state_t state_reg, state_next;
    in_t item_reg, item_next;
    logic [BUF_W-1:0] bb_reg, bb_next;
    logic [BUF_W-1:0] free_reg, free_next;
    logic [15:0] rp_reg, rp_next;
    logic [15:0] wp_reg, wp_next;
    logic [IW-1:0] oldest_reg, oldest_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [LW-1:0] live_reg, live_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] left_reg, left_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic [IW-1:0] f_reg, f_next;
    logic [15:0] off_reg, off_next;
    rec_t rec_reg, rec_next;
    status_t status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [31:0] value_reg, value_next;

    logic [BUF_W-1:0] msg_size;
    logic [BUF_W:0] wp_sum;
    logic [15:0] wp_wrapped;
    logic [BUF_W:0] fu_add;
    logic [BUF_W:0] fu_sum;
    logic [BUF_W-1:0] free_fu;
    logic [BUF_W-1:0] tick_len;
    logic [BUF_W-1:0] cfg_sat;
    logic [IW-1:0] scan_addr;
    logic is_last;

    assign msg_size = BUF_W'(item_reg.byte_count) + BUF_W'(5);
    assign wp_sum = (BUF_W+1)'(wp_reg) + (BUF_W+1)'(msg_size);
    assign wp_wrapped = (wp_sum >= (BUF_W+1)'(bb_reg)) ? 16'(wp_sum - (BUF_W+1)'(bb_reg))
                                                       : 16'(wp_sum);
    always_comb begin
        if (rp_reg <= off_reg) begin
            fu_add = (BUF_W+1)'(off_reg) - (BUF_W+1)'(rp_reg);
        end else begin
            fu_add = (BUF_W+1)'(bb_reg) - (BUF_W+1)'(rp_reg) + (BUF_W+1)'(off_reg);
        end
        fu_sum = (BUF_W+1)'(free_reg) + fu_add;
        free_fu = (fu_sum > (BUF_W+1)'(bb_reg)) ? bb_reg : BUF_W'(fu_sum);
    end

    // rec_reg holds the matched tick, rdata the one after it
    always_comb begin
        if (rdata.offset > rec_reg.offset) begin
            tick_len = BUF_W'(rdata.offset) - BUF_W'(rec_reg.offset);
        end else if (rdata.offset == rec_reg.offset) begin
            tick_len = (rec_reg.messages == 16'd0) ? '0 : bb_reg;
        end else begin
            tick_len = bb_reg - BUF_W'(rec_reg.offset) + BUF_W'(rdata.offset);
        end
    end

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_sat = BUF_W'(1);
        end else if (cfg_wr_data > BUF_MAX) begin
            cfg_sat = BUF_MAX;
        end else begin
            cfg_sat = cfg_wr_data;
        end
    end

    assign scan_addr = wrap_add(oldest_reg, cnt_reg[IW-1:0]);
    assign is_last = (cnt_reg == live_reg - LW'(1));

    always_comb begin
        state_next = state_reg;
        item_next = item_reg;
        bb_next = bb_reg;
        free_next = free_reg;
        rp_next = rp_reg;
        wp_next = wp_reg;
        oldest_next = oldest_reg;
        cur_next = cur_reg;
        live_next = live_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        left_next = left_reg;
        idx_next = idx_reg;
        addr_next = addr_reg;
        f_next = f_reg;
        off_next = off_reg;
        rec_next = rec_reg;
        status_next = status_reg;
        slot_next = slot_reg;
        value_next = value_reg;
        mreq = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next = in_item;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                status_next = ST_OK;
                slot_next = '0;
                value_next = '0;
                cnt_next = '0;
                state_next = S_DONE;
                case (item_reg.cmd)
                    CMD_CLEAR: begin
                        mreq.clr = 1'b1;
                        oldest_next = '0;
                        cur_next = '0;
                        live_next = '0;
                        rp_next = '0;
                        wp_next = '0;
                        free_next = bb_reg;
                    end
                    CMD_START: begin
                        if (live_reg == LW'(TICK_SLOTS)) begin
                            status_next = ST_FULL;
                        end else begin
                            mreq.wr_en = 1'b1;
                            mreq.wr_addr = SLOT_W'(cur_reg);
                            mreq.wr_data = '{tick_time: item_reg.tick_time, offset: wp_reg,
                                             acks: 8'd0, messages: 16'd0};
                            slot_next = SLOT_W'(cur_reg);
                            live_next = live_reg + LW'(1);
                            cur_next = wrap_add(cur_reg, IW'(1));
                        end
                    end
                    CMD_WRITE: begin
                        if (msg_size > free_reg) begin
                            status_next = ST_NO_SPACE;
                        end else begin
                            wp_next = wp_wrapped;
                            free_next = free_reg - msg_size;
                            addr_next = wrap_add(cur_reg, IW'(TICK_SLOTS - 1));
                            mreq.rd_en = 1'b1;
                            mreq.rd_addr = SLOT_W'(wrap_add(cur_reg, IW'(TICK_SLOTS - 1)));
                            state_next = S_MWR;
                        end
                    end
                    CMD_NEXT: begin
                        if (live_reg == '0) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            state_next = S_SRD;
                        end
                    end
                    default: state_next = S_SRD;
                endcase
            end
            S_SRD: begin
                if (cnt_reg == live_reg) begin
                    status_next = ST_NOT_FOUND;
                    state_next = S_DONE;
                end else begin
                    mreq.rd_en = 1'b1;
                    mreq.rd_addr = SLOT_W'(scan_addr);
                    addr_next = scan_addr;
                    state_next = S_SCHK;
                end
            end
            S_SCHK: begin
                // next time: oldest tick answers when no time or an earlier time is given
                if (item_reg.cmd == CMD_NEXT && cnt_reg == '0 &&
                    (!item_reg.time_given || item_reg.tick_time < rdata.tick_time)) begin
                    slot_next = SLOT_W'(addr_reg);
                    value_next = rdata.tick_time;
                    state_next = S_DONE;
                end else if (rdata.tick_time == item_reg.tick_time) begin
                    idx_next = addr_reg;
                    pos_next = cnt_reg;
                    rec_next = rdata;
                    slot_next = SLOT_W'(addr_reg);
                    state_next = S_DONE;
                    case (item_reg.cmd)
                        CMD_ACK_REQ: begin
                            mreq.wr_en = 1'b1;
                            mreq.wr_addr = SLOT_W'(addr_reg);
                            mreq.wr_data = rdata;
                            mreq.wr_data.acks = rdata.acks + item_reg.ack_count;
                        end
                        CMD_ACK_RX: begin
                            cnt_next = '0;
                            state_next = S_DRD;
                        end
                        CMD_SET_CUR: cur_next = addr_reg;
                        CMD_NEXT: begin
                            if (is_last) begin
                                status_next = ST_NOT_FOUND;
                                slot_next = '0;
                            end else begin
                                state_next = S_NRD;
                            end
                        end
                        CMD_LENGTH: begin
                            if (is_last) begin
                                status_next = ST_INCOMPLETE;
                            end else begin
                                state_next = S_NRD;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end else begin
                    cnt_next = cnt_reg + LW'(1);
                    state_next = S_SRD;
                end
            end
            S_DRD: begin
                mreq.rd_en = 1'b1;
                mreq.rd_addr = SLOT_W'(scan_addr);
                addr_next = scan_addr;
                state_next = S_DWR;
            end
            S_DWR: begin
                mreq.wr_en = 1'b1;
                mreq.wr_addr = SLOT_W'(addr_reg);
                mreq.wr_data = rdata;
                mreq.wr_data.acks = rdata.acks - 8'd1;
                if (cnt_reg == pos_reg) begin
                    f_next = oldest_reg;
                    left_next = live_reg;
                    state_next = S_RRD;
                end else begin
                    cnt_next = cnt_reg + LW'(1);
                    state_next = S_DRD;
                end
            end
            S_RRD: begin
                if (left_reg == '0) begin
                    state_next = S_FREE;
                end else begin
                    mreq.rd_en = 1'b1;
                    mreq.rd_addr = SLOT_W'(f_reg);
                    state_next = S_RCHK;
                end
            end
            S_RCHK: begin
                if (rdata.acks == 8'd0) begin
                    left_next = left_reg - LW'(1);
                    f_next = wrap_add(f_reg, IW'(1));
                    state_next = S_RRD;
                end else begin
                    off_next = rdata.offset;
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                if (left_reg != live_reg) begin
                    oldest_next = f_reg;
                    live_next = left_reg;
                    if (left_reg == '0) begin
                        rp_next = wp_reg;
                        free_next = bb_reg;
                    end else begin
                        rp_next = off_reg;
                        free_next = free_fu;
                    end
                end
                state_next = S_DONE;
            end
            S_NRD: begin
                mreq.rd_en = 1'b1;
                mreq.rd_addr = SLOT_W'(wrap_add(idx_reg, IW'(1)));
                addr_next = wrap_add(idx_reg, IW'(1));
                state_next = S_NCHK;
            end
            S_NCHK: begin
                if (item_reg.cmd == CMD_NEXT) begin
                    slot_next = SLOT_W'(addr_reg);
                    value_next = rdata.tick_time;
                end else begin
                    value_next = 32'(tick_len);
                    if (BUF_W'(item_reg.byte_count) < tick_len) begin
                        status_next = ST_TOO_SMALL;
                    end
                end
                state_next = S_DONE;
            end
            S_MWR: begin
                mreq.wr_en = 1'b1;
                mreq.wr_addr = SLOT_W'(addr_reg);
                mreq.wr_data = rdata;
                mreq.wr_data.messages = rdata.messages + 16'd1;
                slot_next = SLOT_W'(addr_reg);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // a size write also clears the ring
        if (cfg_wr_en) begin
            bb_next = cfg_sat;
            mreq.clr = 1'b1;
            mreq.wr_en = 1'b0;
            oldest_next = '0;
            cur_next = '0;
            live_next = '0;
            rp_next = '0;
            wp_next = '0;
            free_next = cfg_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            bb_reg <= BUF_RESET;
            free_reg <= BUF_RESET;
            rp_reg <= '0;
            wp_reg <= '0;
            oldest_reg <= '0;
            cur_reg <= '0;
            live_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
            left_reg <= '0;
        end else begin
            state_reg <= state_next;
            bb_reg <= bb_next;
            free_reg <= free_next;
            rp_reg <= rp_next;
            wp_reg <= wp_next;
            oldest_reg <= oldest_next;
            cur_reg <= cur_next;
            live_reg <= live_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        idx_reg <= idx_next;
        addr_reg <= addr_next;
        f_reg <= f_next;
        off_reg <= off_next;
        rec_reg <= rec_next;
        status_reg <= status_next;
        slot_reg <= slot_next;
        value_reg <= value_next;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res = '{status: status_reg, slot_index: slot_reg, value: value_reg,
                   free_bytes: free_reg};

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= LW'(TICK_SLOTS))
        else $error("live tick count above ring size");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= bb_reg)
        else $error("free bytes above buffer size");

    a_wp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        BUF_W'(wp_reg) < bb_reg)
        else $error("write position outside buffer");

    a_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mreq.rd_en && mreq.wr_en))
        else $error("slot store read and written in one cycle");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !in_valid) |=> state_reg == S_IDLE)
        else $error("sequencer left idle without a transfer");

endmodule
`default_nettype wire

// ===== sv/tick_window_ack_tracker.sv =====
`default_nettype none
// channel   dir  tdata fields (lsb up)                                  tuser
// s_        in   tick_time[31:0] time_given[32] ack_count[40:33]       cmd[2:0]
//                byte_count[56:41]
// m_        out  slot_index[7:0] value[39:8] free_bytes[56:40]         status[2:0]
// cfg_wr_   in   buffer_bytes[16:0], written when cfg_wr_en is high
//
// One command at a time; ring slots are walked with a read state and a check
// state per slot through a single-port slot store with registered read data.
// Write message updates the newest tick. Searches check each slot from the
// oldest; next tick and length also read the following tick, and receive
// acknowledge decrements slots up to the match, then retires slots with no
// acks left from the oldest. Reset and clear empty the ring at once. s_tready
// drops while a command runs; a result waiting on m_tready holds the sequencer.
module tick_window_ack_tracker #(
    parameter int TICK_SLOTS = twat_pkg::DEF_TICK_SLOTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [16:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // tick_time, time_given, ack_count, byte_count
    input  wire logic [2:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // slot_index, value, free_bytes
    output logic [2:0]       m_tuser    // status
);
    import twat_pkg::*;

    in_t in_item;
    res_t res;
    logic res_valid;
    logic res_take;
    mem_req_t mreq;
    rec_t rdata;
    logic m_valid_reg;
    res_t m_res_reg;

    assign in_item = '{cmd: cmd_t'(s_tuser), tick_time: s_tdata[31:0],
                       time_given: s_tdata[32], ack_count: s_tdata[40:33],
                       byte_count: s_tdata[56:41]};

    twat_seq #(.TICK_SLOTS(TICK_SLOTS)) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (in_item),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mreq        (mreq),
        .rdata       (rdata)
    );

    twat_mem #(.TICK_SLOTS(TICK_SLOTS)) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rdata   (rdata)
    );

    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {7'd0, m_res_reg.free_bytes, m_res_reg.value, m_res_reg.slot_index};
    assign m_tuser = m_res_reg.status;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
    import twat_pkg::*;

    localparam int SLOTS = DEF_TICK_SLOTS;

    class window_scoreboard;
        logic [31:0] s_time [SLOTS];
        logic [15:0] s_off [SLOTS];
        logic [7:0]  s_acks [SLOTS];
        logic [15:0] s_msgs [SLOTS];
        int unsigned oldest, current, live, rd_pos, wr_pos, free_cnt, buf_size;
        res_t pending[$];
        int errors;

        function new();
            errors = 0;
            buf_size = 4096;
            clear_ring();
        endfunction

        function void clear_ring();
            for (int i = 0; i < SLOTS; i++) begin
                s_time[i] = '1; s_off[i] = 0; s_acks[i] = 0; s_msgs[i] = 0;
            end
            oldest = 0; current = 0; live = 0; rd_pos = 0; wr_pos = 0;
            free_cnt = buf_size;
        endfunction

        function void set_size(int unsigned v);
            if (v == 0) v = 1;
            if (v > 65536) v = 65536;
            buf_size = v;
            clear_ring();
        endfunction

        function bit lookup(logic [31:0] t, output int unsigned slot, output int unsigned pos);
            slot = 0; pos = 0;
            for (int i = 0; i < live && i < SLOTS; i++) begin
                if (s_time[(oldest + i) % SLOTS] == t) begin
                    slot = (oldest + i) % SLOTS; pos = i;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_command(in_t c);
            res_t r;
            int unsigned idx, pos, sz, left, f, a, b, len, nx;
            r.status = ST_OK; r.slot_index = 0; r.value = 0;
            case (c.cmd)
                CMD_CLEAR: clear_ring();
                CMD_START: begin
                    if (live >= SLOTS) r.status = ST_FULL;
                    else begin
                        idx = current % SLOTS;
                        r.slot_index = 8'(idx);
                        s_time[idx] = c.tick_time; s_off[idx] = 16'(wr_pos);
                        s_acks[idx] = 0; s_msgs[idx] = 0;
                        live++;
                        current = (idx + 1) % SLOTS;
                    end
                end
                CMD_WRITE: begin
                    sz = c.byte_count + 5;
                    if (sz > free_cnt) r.status = ST_NO_SPACE;
                    else begin
                        wr_pos = (wr_pos + sz) % buf_size;
                        free_cnt -= sz;
                        idx = (current + SLOTS - 1) % SLOTS;
                        r.slot_index = 8'(idx);
                        s_msgs[idx] = s_msgs[idx] + 16'd1;
                    end
                end
                CMD_ACK_REQ: begin
                    if (!lookup(c.tick_time, idx, pos)) r.status = ST_NOT_FOUND;
                    else begin
                        r.slot_index = 8'(idx);
                        s_acks[idx] = s_acks[idx] + c.ack_count;
                    end
                end
                CMD_ACK_RX: begin
                    if (!lookup(c.tick_time, idx, pos)) r.status = ST_NOT_FOUND;
                    else begin
                        r.slot_index = 8'(idx);
                        for (int i = 0; i <= pos; i++)
                            s_acks[(oldest + i) % SLOTS] = s_acks[(oldest + i) % SLOTS] - 8'd1;
                        left = live; f = oldest;
                        while (left != 0 && s_acks[f] == 0) begin
                            left--; f = (f + 1) % SLOTS;
                        end
                        if (left != live) begin
                            oldest = f; live = left;
                            if (left == 0) begin
                                rd_pos = wr_pos; free_cnt = buf_size;
                            end else begin
                                a = s_off[f];
                                if (rd_pos <= a) free_cnt += a - rd_pos;
                                else free_cnt += (buf_size - rd_pos) + a;
                                if (free_cnt > buf_size) free_cnt = buf_size;
                                rd_pos = a;
                            end
                        end
                    end
                end
                CMD_SET_CUR: begin
                    if (!lookup(c.tick_time, idx, pos)) r.status = ST_NOT_FOUND;
                    else begin
                        r.slot_index = 8'(idx); current = idx;
                    end
                end
                CMD_NEXT: begin
                    if (live == 0) r.status = ST_NOT_FOUND;
                    else if (!c.time_given || c.tick_time < s_time[oldest]) begin
                        r.slot_index = 8'(oldest); r.value = s_time[oldest];
                    end else if (!lookup(c.tick_time, idx, pos) || pos + 1 >= live)
                        r.status = ST_NOT_FOUND;
                    else begin
                        nx = (idx + 1) % SLOTS;
                        r.slot_index = 8'(nx); r.value = s_time[nx];
                    end
                end
                CMD_LENGTH: begin
                    if (!lookup(c.tick_time, idx, pos)) r.status = ST_NOT_FOUND;
                    else begin
                        r.slot_index = 8'(idx);
                        if (pos + 1 >= live) r.status = ST_INCOMPLETE;
                        else begin
                            a = s_off[idx]; b = s_off[(idx + 1) % SLOTS];
                            if (b > a) len = b - a;
                            else if (b == a) len = (s_msgs[idx] == 0) ? 0 : buf_size;
                            else len = (buf_size - a) + b;
                            r.value = len;
                            if (c.byte_count < len) r.status = ST_TOO_SMALL;
                        end
                    end
                end
                default: ;
            endcase
            r.free_bytes = 17'(free_cnt);
            pending.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.slot_index !== exp.slot_index) begin
                $display("%0t: slot exp %0d got %0d", $time, exp.slot_index, got.slot_index);
                errors++;
            end
            if (got.value !== exp.value) begin
                $display("%0t: value exp %0h got %0h", $time, exp.value, got.value);
                errors++;
            end
            if (got.free_bytes !== exp.free_bytes) begin
                $display("%0t: free exp %0d got %0d", $time, exp.free_bytes, got.free_bytes);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [16:0] cfg_wr_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;

    window_scoreboard sb = new();
    longint cycles = 0;
    bit stim_done = 0;
    logic [31:0] recent_times[$];
    logic [31:0] base_time = 100;

    always #6 aclk = ~aclk;

    tick_window_ack_tracker uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stalls before each transfer
    initial begin
        int gap;
        res_t got;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk iff m_tvalid);
            got.status = status_t'(m_tuser);
            got.slot_index = m_tdata[7:0];
            got.value = m_tdata[39:8];
            got.free_bytes = m_tdata[56:40];
            sb.check_result(got);
        end
    end

    task automatic send_command(cmd_t c, logic [31:0] t, logic g, logic [7:0] ak,
                                logic [15:0] bc, bit burst);
        in_t it;
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        it.cmd = c; it.tick_time = t; it.time_given = g;
        it.ack_count = ak; it.byte_count = bc;
        s_tvalid <= 1;
        s_tuser <= c;
        s_tdata <= {7'd0, bc, ak, g, t};
        @(posedge aclk iff s_tready);
        sb.note_command(it);
    endtask

    task automatic write_size(int unsigned v);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= 17'(v);
        @(posedge aclk);
        sb.set_size(v);
        cfg_wr_en <= 0;
        recent_times.delete();
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_time();
        if (recent_times.size() != 0 && $urandom_range(0, 9) != 0)
            return recent_times[$urandom_range(0, recent_times.size() - 1)];
        return $urandom();
    endfunction

    initial begin
        bit burst;
        int k;
        cmd_t c;
        logic [31:0] t;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: every command, empty ring, extremes, ring full
        send_command(CMD_NEXT, 0, 0, 0, 0, 0);
        send_command(CMD_WRITE, 0, 0, 0, 16'hFFFF, 0);
        send_command(CMD_WRITE, 0, 0, 0, 0, 0);
        send_command(CMD_START, 32'hFFFF_FFFF, 1, 8'hFF, 0, 0);
        send_command(CMD_LENGTH, 32'hFFFF_FFFF, 0, 0, 16'hFFFF, 0);
        send_command(CMD_START, 0, 0, 0, 0, 0);
        send_command(CMD_LENGTH, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_command(CMD_NEXT, 32'hFFFF_FFFF, 1, 0, 0, 0);
        send_command(CMD_NEXT, 5, 1, 0, 0, 0);
        send_command(CMD_ACK_REQ, 0, 0, 8'hFF, 0, 0);
        send_command(CMD_ACK_RX, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_command(CMD_ACK_RX, 0, 0, 0, 0, 1);
        send_command(CMD_SET_CUR, 0, 0, 0, 0, 0);
        send_command(CMD_START, 7, 0, 0, 0, 0);
        for (k = 0; k < 34; k++) send_command(CMD_START, k, 0, 0, 0, 1);
        send_command(CMD_CLEAR, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_size(0);
                1: write_size(65536);
                2: write_size(17'h1FFFF);
                3: write_size(64);
                4: write_size(4096);
                default: write_size($urandom_range(1, 600));
            endcase
            for (int n = 0; n < 320; n++) begin
                burst = ($urandom_range(0, 4) == 0);
                k = $urandom_range(0, 99);
                if (k < 16) begin
                    base_time += $urandom_range(1, 3);
                    t = ($urandom_range(0, 19) == 0) ? $urandom() : base_time;
                    recent_times.push_back(t);
                    if (recent_times.size() > 40) void'(recent_times.pop_front());
                    send_command(CMD_START, t, 1'($urandom_range(0, 1)), 8'($urandom()),
                                 16'($urandom()), burst);
                end else if (k < 38) begin
                    send_command(CMD_WRITE, $urandom(), 1'($urandom_range(0, 1)),
                                 8'($urandom()),
                                 16'(($urandom_range(0, 9) == 0) ? $urandom()
                                                                 : $urandom_range(0, 40)),
                                 burst);
                end else if (k < 52) begin
                    send_command(CMD_ACK_REQ, pick_time(), 1'($urandom_range(0, 1)),
                                 8'(($urandom_range(0, 9) == 0) ? $urandom()
                                                                : $urandom_range(1, 3)),
                                 16'($urandom()), burst);
                end else if (k < 70) begin
                    send_command(CMD_ACK_RX, pick_time(), 1'($urandom_range(0, 1)),
                                 8'($urandom()), 16'($urandom()), burst);
                end else if (k < 75) begin
                    send_command(CMD_SET_CUR, pick_time(), 1'($urandom_range(0, 1)),
                                 8'($urandom()), 16'($urandom()), burst);
                end else if (k < 86) begin
                    send_command(CMD_NEXT, pick_time() - $urandom_range(0, 1),
                                 1'($urandom_range(0, 1)), 8'($urandom()), 16'($urandom()),
                                 burst);
                end else if (k < 98) begin
                    send_command(CMD_LENGTH, pick_time(), 1'($urandom_range(0, 1)),
                                 8'($urandom()),
                                 16'(($urandom_range(0, 3) == 0) ? $urandom()
                                                                 : $urandom_range(0, 200)),
                                 burst);
                end else begin
                    c = CMD_CLEAR;
                    send_command(c, $urandom(), 1'($urandom_range(0, 1)), 8'($urandom()),
                                 16'($urandom()), burst);
                    recent_times.delete();
                end
            end
        end
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
